>>> rtl/sba_pkg.sv
// Shared types, codes and helpers of the staggered buffer accumulator.
package sba_pkg;

    localparam int MAX_BUFFERS  = 16;
    localparam int MAX_LENGTH   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int BUF_W        = 4;
    localparam int IDX_W        = 6;
    localparam int POS_W        = 11;
    localparam int ACC_W        = 64;
    localparam int CNT_W        = 32;
    localparam int FILL_AW      = BUF_W + IDX_W;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_NUM_BUFFERS = 2'd0;
    localparam logic [1:0] REG_LENGTH      = 2'd1;
    localparam logic [1:0] REG_INTERVAL    = 2'd2;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_AVERAGE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_REPORT,
        S_AVG_RD,
        S_DIV,
        S_AVG_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    function automatic logic [4:0] eff_buffers(input logic [4:0] n);
        if (n == 5'd0) return 5'd1;
        if (n > 5'd16) return 5'd16;
        return n;
    endfunction

    function automatic logic [6:0] eff_length(input logic [6:0] n);
        if (n == 7'd0) return 7'd1;
        if (n > 7'd64) return 7'd64;
        return n;
    endfunction

    function automatic logic [6:0] eff_interval(input logic [6:0] n);
        if (n > 7'd64) return 7'd64;
        return n;
    endfunction

endpackage

>>> rtl/sba_div.sv
// Restoring divider, one quotient bit a cycle: 64-bit dividend by 32-bit divisor.
module sba_div
    import sba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_ctl_t         ctl,
    output logic [ACC_W-1:0] quotient
);

    logic [CNT_W:0]   rem_reg;
    logic [ACC_W-1:0] quo_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;

    assign rem_sh  = {rem_reg[CNT_W-1:0], quo_reg[ACC_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(ACC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!rem_sub[CNT_W]) begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> rtl/staggered_buffer_accumulator.sv
// Top level of the staggered buffer accumulator: sequencer, stores and output register.
// Usage:
//   s_ channel takes one word per item: tuser = operation, tdata = value and entry_index.
//   m_ channel gives a report (tuser 0) at the end of each step or an average (tuser 1).
//   cfg_we/cfg_index/cfg_wdata write a register; any write to registers 0..2 restarts
//   all buffers, positions, sums and the count.
// Sequencing:
//   An add word that fills no buffer is taken in S_IDLE alone; the one that ends a step
//   also passes through S_REPORT for the report. A full buffer walks the accumulation
//   store through one shared saturating adder, reading and then writing each entry.
//   An average read runs the bit-serial divider (64 steps) unless the count is zero.
//   Reset-averaging and unused operations give no word.
// Reset and flow:
//   aresetn (synchronous) loads the default registers and clears every sum at once
//   through per-entry valid bits; no clearing pass is needed.
//   A result is held in the output register while m_tready is low; the sequencer
//   waits on it and s_tready stays low until it is idle again.
module staggered_buffer_accumulator
    import sba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], entry_index[37:32], zero[39:38]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // refill_valid[0], refill_buffer[4:1],
                                   // multiple_refill_error[5], average_value[37:6],
                                   // average_empty[38], zero[39]
    output logic        m_tuser    // result_kind
);

    state_t state_reg, state_next;

    logic [4:0] nbuf_reg;
    logic [6:0] len_reg;
    logic [6:0] intv_reg;

    logic signed [POS_W-1:0] pos_reg [MAX_BUFFERS];
    logic signed [POS_W-1:0] pos_init [MAX_BUFFERS];
    logic [BUF_W-1:0] cursor_reg;
    logic [BUF_W-1:0] cur_buf_reg;
    logic             flag_valid_reg;
    logic [BUF_W-1:0] flag_buf_reg;
    logic             flag_err_reg;
    logic             end_step_reg;
    logic [CNT_W-1:0] sets_reg;
    logic [IDX_W:0]   walk_reg;

    logic [SAMPLE_WIDTH-1:0] fill_mem [MAX_BUFFERS*MAX_LENGTH];
    logic [SAMPLE_WIDTH-1:0] fill_rd_reg;
    logic [ACC_W-1:0]        acc_mem [MAX_LENGTH];
    logic [ACC_W-1:0]        acc_rd_reg;
    logic                    acc_rd_valid_reg;
    logic [MAX_LENGTH-1:0]   acc_valid_reg;
    logic [IDX_W-1:0]        acc_raddr_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic        out_rv_reg;
    logic [3:0]  out_rb_reg;
    logic        out_err_reg;
    logic [31:0] out_avg_reg;
    logic        out_empty_reg;

    logic        avg_neg_reg;
    logic        avg_empty_reg;

    logic        accept;
    logic        restart;
    logic [6:0]  new_intv;
    logic [4:0]  ebuf;
    logic signed [POS_W-1:0] elen;
    logic [BUF_W-1:0] b_sel;
    logic signed [POS_W-1:0] pos_cur;
    logic signed [POS_W-1:0] pos_inc;
    logic [1:0]  op;
    logic        out_free;
    logic        load_out;

    logic [ACC_W-1:0] acc_cur;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sum_sat;
    logic [ACC_W-1:0] mag;
    logic             div_start;
    div_ctl_t         div_ctl;
    logic [ACC_W-1:0] quo;
    logic [31:0]      avg_val;

    assign op       = s_tuser;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign restart  = cfg_we && (cfg_index == REG_NUM_BUFFERS || cfg_index == REG_LENGTH
                      || cfg_index == REG_INTERVAL);
    assign new_intv = eff_interval((cfg_index == REG_INTERVAL) ? cfg_wdata : intv_reg);
    assign ebuf     = eff_buffers(nbuf_reg);
    assign elen     = POS_W'(eff_length(len_reg));
    assign b_sel    = ({1'b0, cursor_reg} >= ebuf) ? '0 : cursor_reg;
    assign pos_cur  = pos_reg[b_sel];
    assign pos_inc  = pos_cur + POS_W'(1);

    always_comb begin
        for (int b = 0; b < MAX_BUFFERS; b++) begin
            pos_init[b] = -(POS_W'(new_intv) * POS_W'(b)) - POS_W'(1);
        end
    end

    // saturating accumulate datapath
    assign acc_cur = acc_rd_valid_reg ? acc_rd_reg : '0;
    assign sum     = {acc_cur[ACC_W-1], acc_cur}
                     + {{(ACC_W-SAMPLE_WIDTH+1){fill_rd_reg[SAMPLE_WIDTH-1]}}, fill_rd_reg};
    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    assign mag = acc_cur[ACC_W-1] ? (~acc_cur + ACC_W'(1)) : acc_cur;

    sba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag),
        .divisor  (sets_reg),
        .ctl      (div_ctl),
        .quotient (quo)
    );

    always_comb begin
        if (!avg_neg_reg) begin
            avg_val = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end else if (quo > 64'h8000_0000) begin
            avg_val = 32'h8000_0000;
        end else begin
            avg_val = 32'd0 - quo[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_ADD) begin
                    if (pos_inc >= elen) begin
                        state_next = S_ACC_RD;
                    end else if ({1'b0, b_sel} + 5'd1 >= ebuf) begin
                        state_next = S_REPORT;
                    end
                end else if (accept && op == OP_READ) begin
                    state_next = S_AVG_RD;
                end
            end
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: begin
                if (walk_reg + 7'd1 >= 7'(elen)) begin
                    state_next = end_step_reg ? S_REPORT : S_IDLE;
                end else begin
                    state_next = S_ACC_RD;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_AVG_RD: begin
                if (sets_reg == '0) begin
                    state_next = S_AVG_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_ctl.done) state_next = S_AVG_OUT;
            end
            S_AVG_OUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbuf_reg       <= 5'd16;
            len_reg        <= 7'd64;
            intv_reg       <= 7'd8;
            for (int b = 0; b < MAX_BUFFERS; b++) begin
                pos_reg[b] <= -POS_W'(8 * b) - POS_W'(1);
            end
            cursor_reg     <= '0;
            flag_valid_reg <= 1'b0;
            flag_buf_reg   <= '0;
            flag_err_reg   <= 1'b0;
            sets_reg       <= '0;
            acc_valid_reg  <= '0;
            walk_reg       <= '0;
            end_step_reg   <= 1'b0;
            cur_buf_reg    <= '0;
        end else if (restart) begin
            unique case (cfg_index)
                REG_NUM_BUFFERS: nbuf_reg <= cfg_wdata[4:0];
                REG_LENGTH:      len_reg  <= cfg_wdata;
                REG_INTERVAL:    intv_reg <= cfg_wdata;
                default:         nbuf_reg <= nbuf_reg;
            endcase
            for (int b = 0; b < MAX_BUFFERS; b++) begin
                pos_reg[b] <= pos_init[b];
            end
            cursor_reg     <= '0;
            flag_valid_reg <= 1'b0;
            flag_buf_reg   <= '0;
            flag_err_reg   <= 1'b0;
            sets_reg       <= '0;
            acc_valid_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept && op == OP_ADD) begin
                        cur_buf_reg  <= b_sel;
                        walk_reg     <= '0;
                        end_step_reg <= ({1'b0, b_sel} + 5'd1 >= ebuf);
                        cursor_reg   <= ({1'b0, b_sel} + 5'd1 >= ebuf) ? '0
                                        : b_sel + BUF_W'(1);
                        if (pos_inc < elen) begin
                            pos_reg[b_sel] <= pos_inc;
                            if (pos_inc == '0) begin
                                if (flag_valid_reg) begin
                                    flag_err_reg <= 1'b1;
                                end else begin
                                    flag_valid_reg <= 1'b1;
                                    flag_buf_reg   <= b_sel;
                                end
                            end
                        end
                    end else if (accept && op == OP_CLEAR) begin
                        acc_valid_reg <= '0;
                        sets_reg      <= '0;
                    end
                end
                S_ACC_WR: begin
                    acc_valid_reg[walk_reg[IDX_W-1:0]] <= 1'b1;
                    walk_reg <= walk_reg + 7'd1;
                    if (walk_reg + 7'd1 >= 7'(elen)) begin
                        pos_reg[cur_buf_reg] <= '0;
                        if (sets_reg != '1) sets_reg <= sets_reg + CNT_W'(1);
                        if (flag_valid_reg) begin
                            flag_err_reg <= 1'b1;
                        end else begin
                            flag_valid_reg <= 1'b1;
                            flag_buf_reg   <= cur_buf_reg;
                        end
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        flag_valid_reg <= 1'b0;
                        flag_buf_reg   <= '0;
                        flag_err_reg   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // stores
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && accept && op == OP_ADD && pos_cur >= 0 && pos_cur < elen)
        begin
            fill_mem[{b_sel, pos_cur[IDX_W-1:0]}] <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        fill_rd_reg <= fill_mem[{cur_buf_reg, walk_reg[IDX_W-1:0]}];
    end

    always_comb begin
        acc_raddr_reg = walk_reg[IDX_W-1:0];
        if (state_reg == S_IDLE) acc_raddr_reg = s_tdata[37:32];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_ACC_WR) begin
            acc_mem[walk_reg[IDX_W-1:0]] <= sum_sat;
        end
        if (state_reg == S_IDLE || state_reg == S_ACC_RD) begin
            acc_rd_reg       <= acc_mem[acc_raddr_reg];
            acc_rd_valid_reg <= acc_valid_reg[acc_raddr_reg];
        end
        if (state_reg == S_AVG_RD) begin
            avg_neg_reg   <= acc_cur[ACC_W-1];
            avg_empty_reg <= (sets_reg == '0);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (state_reg == S_REPORT) begin
                out_kind_reg  <= KIND_REPORT;
                out_rv_reg    <= flag_valid_reg;
                out_rb_reg    <= flag_buf_reg;
                out_err_reg   <= flag_err_reg;
                out_avg_reg   <= '0;
                out_empty_reg <= 1'b0;
            end else begin
                out_kind_reg  <= KIND_AVERAGE;
                out_rv_reg    <= 1'b0;
                out_rb_reg    <= '0;
                out_err_reg   <= 1'b0;
                out_avg_reg   <= avg_empty_reg ? 32'd0 : avg_val;
                out_empty_reg <= avg_empty_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {1'b0, out_empty_reg, out_avg_reg, out_err_reg, out_rb_reg, out_rv_reg};

endmodule
